// ===== src/pctr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pctr_pkg
// Shared types and codes for the per-channel tick ring: command and record
// layouts, result status codes, command classes and back-end states.
// ----------------------------------------------------------------------------
package pctr_pkg;

	localparam int TIME_W  = 63;
	localparam int FIELD_W = 32;
	localparam int CHAN_W  = 4;
	localparam int REC_W   = TIME_W + 2 * FIELD_W + 1;

	// a query needs at least this many stored records to answer anything
	localparam int MIN_QUERY_FILL = 2;

	typedef enum logic [1:0] {
		ST_APPEND = 2'd0,
		ST_RECORD = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_APPEND,
		CLS_QUERY,
		CLS_RANGE
	} cls_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN_RD,
		BK_SCAN_CMP,
		BK_EMIT_RD,
		BK_EMIT_OUT,
		BK_EMPTY
	} bk_state_t;

	typedef struct packed {
		logic [TIME_W-1:0]  stamp;
		logic [FIELD_W-1:0] price;
		logic [FIELD_W-1:0] volume;
		logic               buy;
	} rec_t;

	typedef struct packed {
		cls_t              cls;
		logic [CHAN_W-1:0] channel;
		rec_t              rec;
	} cmd_t;

endpackage : pctr_pkg
`default_nettype wire

// ===== src/pctr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pctr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pctr_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule : pctr_ram
`default_nettype wire

// ===== src/pctr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pctr_front
// Input side: accept items, classify them (append, query, channel out of
// range) and hold them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pctr_front
	import pctr_pkg::*;
#(
	parameter int NUM_CHANNELS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                operation,
	input  wire logic [CHAN_W-1:0]   channel,
	input  wire logic [TIME_W-1:0]   time_ms,
	input  wire logic [FIELD_W-1:0]  price_bits,
	input  wire logic [FIELD_W-1:0]  volume_bits,
	input  wire logic                is_buy,
	output logic                     cmd_valid,
	output cmd_t                     cmd,
	input  wire logic                cmd_pop
);

	localparam logic [CHAN_W:0] NCH = (CHAN_W + 1)'(NUM_CHANNELS);

	cmd_t       entry_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	cmd_t       new_cmd;
	logic       push;

	always_comb begin
		new_cmd.channel    = channel;
		new_cmd.rec.stamp  = time_ms;
		new_cmd.rec.price  = price_bits;
		new_cmd.rec.volume = volume_bits;
		new_cmd.rec.buy    = is_buy;
		if ({1'b0, channel} >= NCH) begin
			new_cmd.cls = CLS_RANGE;
		end else if (operation) begin
			new_cmd.cls = CLS_QUERY;
		end else begin
			new_cmd.cls = CLS_APPEND;
		end
	end

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (cmd_pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule : pctr_front
`default_nettype wire

// ===== src/pctr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pctr_back
// Execution side: ring pointers and fill counts, record memory, backward
// scan for queries and the output register.
// ----------------------------------------------------------------------------
module pctr_back
	import pctr_pkg::*;
#(
	parameter int DEPTH        = 64,
	parameter int NUM_CHANNELS = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	input  wire cmd_t  cmd,
	output logic       cmd_pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output status_t    out_status,
	output rec_t       out_rec,
	output logic       out_last
);

	localparam int SW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int AW  = $clog2(NUM_CHANNELS * DEPTH);

	localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL      = CW'(DEPTH);
	localparam logic [CW-1:0] MIN_FILL  = CW'(MIN_QUERY_FILL);

	bk_state_t          state_q, state_d;
	logic [SW-1:0]      wp_q   [NUM_CHANNELS];
	logic [CW-1:0]      fill_q [NUM_CHANNELS];
	logic [AW-1:0]      base_q, base_d;
	logic [TIME_W-1:0]  qtime_q, qtime_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [CW-1:0]      j_q, j_d;
	logic [CW-1:0]      rem_q, rem_d;
	logic [SW-1:0]      slot_q, slot_d;

	logic               out_valid_q;
	status_t            out_status_q;
	rec_t               out_rec_q;
	logic               out_last_q;

	logic [CHW-1:0]     idx;
	logic [SW-1:0]      cur_wp;
	logic [CW-1:0]      cur_fill;
	logic [AW-1:0]      ch_base;
	logic               out_free;
	logic               ptr_upd;
	logic               load;
	status_t            ld_status;
	rec_t               ld_rec;
	logic               ld_last;

	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_wr_addr;
	logic [AW-1:0]      ram_rd_addr;
	rec_t               ram_rd_data;

	pctr_ram #(
		.WIDTH(REC_W),
		.DEPTH(NUM_CHANNELS * DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(cmd.rec),
		.rd_en  (ram_re),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	assign idx         = cmd.channel[CHW-1:0];
	assign cur_wp      = wp_q[idx];
	assign cur_fill    = fill_q[idx];
	assign ch_base     = AW'(AW'(idx) * AW'(DEPTH));
	assign ram_wr_addr = ch_base + AW'(cur_wp);
	assign ram_rd_addr = base_q + AW'(slot_q);
	assign out_free    = !out_valid_q || !out_stall;

	always_comb begin
		state_d   = state_q;
		base_d    = base_q;
		qtime_d   = qtime_q;
		cnt_d     = cnt_q;
		j_d       = j_q;
		rem_d     = rem_q;
		slot_d    = slot_q;
		cmd_pop   = 1'b0;
		ptr_upd   = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		load      = 1'b0;
		ld_status = ST_APPEND;
		ld_rec    = '0;
		ld_last   = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					case (cmd.cls)
						CLS_APPEND: begin
							ram_we  = 1'b1;
							ptr_upd = 1'b1;
							load    = 1'b1;
						end
						CLS_QUERY: begin
							if (cur_fill < MIN_FILL) begin
								load      = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								base_d  = ch_base;
								qtime_d = cmd.rec.stamp;
								cnt_d   = cur_fill;
								j_d     = '0;
								slot_d  = (cur_wp == '0) ? LAST_SLOT : cur_wp - 1'b1;
								state_d = BK_SCAN_RD;
							end
						end
						default: begin
							load      = 1'b1;
							ld_status = ST_RANGE;
						end
					endcase
				end
			end
			BK_SCAN_RD: begin
				ram_re  = 1'b1;
				state_d = BK_SCAN_CMP;
			end
			BK_SCAN_CMP: begin
				if (ram_rd_data.stamp < qtime_q) begin
					// older record found: emit everything after it
					if (j_q == '0) begin
						state_d = BK_EMPTY;
					end else begin
						rem_d   = j_q;
						slot_d  = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
						state_d = BK_EMIT_RD;
					end
				end else if (j_q + 1'b1 == cnt_q) begin
					// nothing older stored: emit all, starting here
					rem_d   = cnt_q;
					state_d = BK_EMIT_RD;
				end else begin
					j_d     = j_q + 1'b1;
					slot_d  = (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
					state_d = BK_SCAN_RD;
				end
			end
			BK_EMIT_RD: begin
				ram_re  = 1'b1;
				state_d = BK_EMIT_OUT;
			end
			BK_EMIT_OUT: begin
				if (out_free) begin
					load      = 1'b1;
					ld_status = ST_RECORD;
					ld_rec    = ram_rd_data;
					ld_last   = (rem_q == CW'(1));
					if (rem_q == CW'(1)) begin
						state_d = BK_IDLE;
					end else begin
						rem_d   = rem_q - 1'b1;
						slot_d  = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
						state_d = BK_EMIT_RD;
					end
				end
			end
			BK_EMPTY: begin
				if (out_free) begin
					load      = 1'b1;
					ld_status = ST_EMPTY;
					state_d   = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ptr_upd) begin
				wp_q[idx] <= (cur_wp == LAST_SLOT) ? '0 : cur_wp + 1'b1;
				if (cur_fill != FULL) begin
					fill_q[idx] <= cur_fill + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		base_q  <= base_d;
		qtime_q <= qtime_d;
		cnt_q   <= cnt_d;
		j_q     <= j_d;
		rem_q   <= rem_d;
		slot_q  <= slot_d;
		if (load) begin
			out_status_q <= ld_status;
			out_rec_q    <= ld_rec;
			out_last_q   <= ld_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_rec    = out_rec_q;
	assign out_last   = out_last_q;

endmodule : pctr_back
`default_nettype wire

// ===== src/per_channel_tick_ring_with_time_query_unit.sv =====
`default_nettype none
// Answer: an append, an out-of-range item or a short query loads the output register as the
// back end pops it. Throughput: appends run at one item per cycle while the output
// is taken. A query holds the back end, which pops no new item until it is done; its single
// read port reads and compares each record scanned, then reads out each record returned.
// Reset: ring pointers, fill counts, queue pointers and output valid flag clear at once; the
// record memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// per_channel_tick_ring_with_time_query_unit
// One ring of DEPTH tick records per channel. An append stores a record at the
// channel's write pointer; a query returns, oldest first, every record newer
// than the newest one stamped before the query time.
// ----------------------------------------------------------------------------
module per_channel_tick_ring_with_time_query_unit
	import pctr_pkg::*;
#(
	parameter int DEPTH        = 64,
	parameter int NUM_CHANNELS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                operation,
	input  wire logic [CHAN_W-1:0]   channel,
	input  wire logic [TIME_W-1:0]   time_ms,
	input  wire logic [FIELD_W-1:0]  price_bits,
	input  wire logic [FIELD_W-1:0]  volume_bits,
	input  wire logic                is_buy,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               status,
	output logic [TIME_W-1:0]        out_time_ms,
	output logic [FIELD_W-1:0]       out_price_bits,
	output logic [FIELD_W-1:0]       out_volume_bits,
	output logic                     out_buy,
	output logic                     last
);

	// front to back queue head and back-end result
	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_pop;
	status_t res_status;
	rec_t    res_rec;

	// Front end: classify each item and hold it in a two-entry queue so the
	// input can take up to two items while the back end walks a ring.
	pctr_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.channel    (channel),
		.time_ms    (time_ms),
		.price_bits (price_bits),
		.volume_bits(volume_bits),
		.is_buy     (is_buy),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	// Back end: update pointers on append, scan backward from the newest
	// record on query, then replay the newer records oldest first.
	pctr_back #(
		.DEPTH       (DEPTH),
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_status(res_status),
		.out_rec   (res_rec),
		.out_last  (last)
	);

	// Unpack the result record onto the output fields; non-record answers
	// carry an all-zero record.
	assign status          = res_status;
	assign out_time_ms     = res_rec.stamp;
	assign out_price_bits  = res_rec.price;
	assign out_volume_bits = res_rec.volume;
	assign out_buy         = res_rec.buy;

endmodule : per_channel_tick_ring_with_time_query_unit
`default_nettype wire
